@@ rtl/ordl_pkg.sv @@
// Shared types and codes for the ordered pair list.
`default_nettype none

package ordl_pkg;

   // Fixed port widths of the request and response words
   localparam int OPCODE_W    = 3;
   localparam int POS_PORT_W  = 5;
   localparam int END_PORT_W  = 4;
   localparam int DATA_PORT_W = 32;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_RANGE  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 3'd0,
      STAT_FULL  = 3'd1,
      STAT_POS   = 3'd2,
      STAT_END   = 3'd3,
      STAT_ORDER = 3'd4
   } status_type;

   // Broadcast along the chain: what every cell does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_DRAIN = 1'b1
   } state_type;

endpackage

`default_nettype wire

@@ rtl/ordl_cell.sv @@
// One list slot: holds a pair and shifts with its neighbors on insert or delete.
`default_nettype none

module ordl_cell
   import ordl_pkg::*;
#(
   parameter int INDEX  = 0,
   parameter int IDX_W  = 4,
   parameter int PAIR_W = 64
) (
   input  wire logic              clock,
   input  wire cell_op_type       op,
   input  wire logic [IDX_W-1:0]  pos,
   input  wire logic [PAIR_W-1:0] lower_pair,
   input  wire logic [PAIR_W-1:0] upper_pair,
   input  wire logic [PAIR_W-1:0] new_pair,
   output logic      [PAIR_W-1:0] pair
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [PAIR_W-1:0] pair_ff;
   logic [PAIR_W-1:0] pair_in;

   always_comb begin
      pair_in = pair_ff;
      case (op)
         CELL_INSERT: begin
            // move up above the slot, load the new pair at it
            if (MY_IDX > pos) begin
               pair_in = lower_pair;
            end else if (MY_IDX == pos) begin
               pair_in = new_pair;
            end
         end
         CELL_DELETE: begin
            // close the gap from above
            if (MY_IDX >= pos) begin
               pair_in = upper_pair;
            end
         end
         default: begin
            pair_in = pair_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   assign pair = pair_ff;

endmodule

`default_nettype wire

@@ rtl/ordered_pair_list.sv @@
// Top level of the ordered pair list: control, cell chain and response register.
//
//   channel   ports                              handshake
//   --------  ---------------------------------  ---------------------------------
//   request   req_opcode .. req_second_value     taken at an edge with start & !busy
//   response  rsp_status .. rsp_last             rsp_valid high on each word
//
// Each accepted request word gives its first response word in the next cycle.
// Append, insert, remove and read leave busy low, so a new request may follow
// in the very next cycle. A range removal of n pairs deletes one pair per cycle
// through the cell chain and holds busy high while the remaining pairs drain,
// giving n response words in consecutive cycles, the final one with
// rsp_last. Reset (synchronous) empties the list; slot contents are not cleared
// and only slots below the fill count are ever read. The receiver cannot stall.
`default_nettype none

module ordered_pair_list
   import ordl_pkg::*;
#(
   parameter int LIST_DEPTH    = 16,
   parameter int ELEMENT_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [OPCODE_W-1:0]    req_opcode,
   input  wire logic [POS_PORT_W-1:0]  req_position,
   input  wire logic [END_PORT_W-1:0]  req_end_position,
   input  wire logic [DATA_PORT_W-1:0] req_first_value,
   input  wire logic [DATA_PORT_W-1:0] req_second_value,
   output logic                        rsp_valid,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [DATA_PORT_W-1:0]      rsp_pair_first,
   output logic [DATA_PORT_W-1:0]      rsp_pair_second,
   output logic [COUNT_W-1:0]          rsp_entry_count,
   output logic                        rsp_last
);

   // count width holds 0..LIST_DEPTH; index width addresses a slot
   localparam int POS_W  = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CMP_W  = (POS_W > POS_PORT_W) ? POS_W : POS_PORT_W;
   localparam int PAIR_W = 2 * ELEMENT_WIDTH;

   // control state
   state_type         state_ff, state_in;
   logic [POS_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  final_ff, final_in;
   logic [IDX_W-1:0]  range_pos_ff, range_pos_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [DATA_PORT_W-1:0] rsp_first_ff, rsp_first_in;
   logic [DATA_PORT_W-1:0] rsp_second_ff, rsp_second_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   // chain control and data
   cell_op_type        cell_op;
   logic [IDX_W-1:0]   cell_pos;
   logic [PAIR_W-1:0]  new_pair;
   logic [PAIR_W-1:0]  slot_pair [LIST_DEPTH];
   logic [PAIR_W-1:0]  rd_pair;
   logic [IDX_W-1:0]   rd_idx;

   // widened request fields for compares
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] end_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] span;
   logic             full;

   assign pos_ext = CMP_W'(req_position);
   assign end_ext = CMP_W'(req_end_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign span    = end_ext - pos_ext;
   assign full    = (count_ff == POS_W'(LIST_DEPTH));

   // values are kept at element width
   assign new_pair = {ELEMENT_WIDTH'(req_first_value), ELEMENT_WIDTH'(req_second_value)};

   // ---------------------------------------------------------------------
   // Cell chain: every slot shifts in the same cycle
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_slot
      logic [PAIR_W-1:0] lower;
      logic [PAIR_W-1:0] upper;

      if (i == 0) begin : g_bottom
         assign lower = '0;
      end else begin : g_lower
         assign lower = slot_pair[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_top
         // top slot falls out of range on delete; its content is never read
         assign upper = slot_pair[i];
      end else begin : g_upper
         assign upper = slot_pair[i+1];
      end

      ordl_cell #(
         .INDEX  (i),
         .IDX_W  (IDX_W),
         .PAIR_W (PAIR_W)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .pos        (cell_pos),
         .lower_pair (lower),
         .upper_pair (upper),
         .new_pair   (new_pair),
         .pair       (slot_pair[i])
      );
   end

   // single read port on the chain: the request slot, or the drain slot
   assign rd_idx  = (state_ff == S_DRAIN) ? range_pos_ff : IDX_W'(pos_ext);
   assign rd_pair = slot_pair[rd_idx];

   // ---------------------------------------------------------------------
   // Control: decode the request word, drive the chain, build the response
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      final_in      = final_ff;
      range_pos_in  = range_pos_ff;
      cell_op       = CELL_HOLD;
      cell_pos      = IDX_W'(pos_ext);
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_first_in  = '0;
      rsp_second_in = '0;
      rsp_count_in  = COUNT_W'(count_ff);
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               unique case (op_type'(req_opcode))
                  OP_APPEND: begin
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        // append is insert at the fill count
                        cell_op  = CELL_INSERT;
                        cell_pos = IDX_W'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        rsp_status_in = STAT_POS;
                     end else begin
                        cell_op  = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_status_in = STAT_POS;
                     end else begin
                        cell_op       = CELL_DELETE;
                        count_in      = count_ff - 1'b1;
                        rsp_first_in  = DATA_PORT_W'(rd_pair[PAIR_W-1 -: ELEMENT_WIDTH]);
                        rsp_second_in = DATA_PORT_W'(rd_pair[ELEMENT_WIDTH-1:0]);
                     end
                  end
                  OP_RANGE: begin
                     if (end_ext >= cnt_ext) begin
                        rsp_status_in = STAT_END;
                     end else if (pos_ext > end_ext) begin
                        rsp_status_in = STAT_ORDER;
                     end else begin
                        // drop the first pair now, drain the rest one per cycle
                        cell_op       = CELL_DELETE;
                        count_in      = count_ff - 1'b1;
                        final_in      = POS_W'(cnt_ext - span - 1'b1);
                        rem_in        = POS_W'(span);
                        range_pos_in  = IDX_W'(pos_ext);
                        rsp_first_in  = DATA_PORT_W'(rd_pair[PAIR_W-1 -: ELEMENT_WIDTH]);
                        rsp_second_in = DATA_PORT_W'(rd_pair[ELEMENT_WIDTH-1:0]);
                        rsp_last_in   = (span == '0);
                        if (span != '0) begin
                           state_in = S_DRAIN;
                        end
                     end
                  end
                  OP_READ: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_status_in = STAT_POS;
                     end else begin
                        rsp_first_in  = DATA_PORT_W'(rd_pair[PAIR_W-1 -: ELEMENT_WIDTH]);
                        rsp_second_in = DATA_PORT_W'(rd_pair[ELEMENT_WIDTH-1:0]);
                     end
                  end
                  default: begin
                     // unused opcodes: answer ok, touch nothing
                     rsp_status_in = STAT_OK;
                  end
               endcase
               if ((op_type'(req_opcode) == OP_RANGE) && (end_ext < cnt_ext)
                   && (pos_ext <= end_ext)) begin
                  rsp_count_in = COUNT_W'(final_in);
               end else begin
                  rsp_count_in = COUNT_W'(count_in);
               end
            end
         end
         S_DRAIN: begin
            // advance the range: delete at the same slot every cycle
            rsp_valid_in  = 1'b1;
            cell_op       = CELL_DELETE;
            cell_pos      = range_pos_ff;
            count_in      = count_ff - 1'b1;
            rem_in        = rem_ff - 1'b1;
            rsp_first_in  = DATA_PORT_W'(rd_pair[PAIR_W-1 -: ELEMENT_WIDTH]);
            rsp_second_in = DATA_PORT_W'(rd_pair[ELEMENT_WIDTH-1:0]);
            rsp_count_in  = COUNT_W'(final_ff);
            rsp_last_in   = (rem_ff == POS_W'(1));
            if (rem_ff == POS_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      final_ff      <= final_in;
      range_pos_ff  <= range_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff == S_DRAIN);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pair_first  = rsp_first_ff;
   assign rsp_pair_second = rsp_second_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // every accepted request word answers in the next cycle
   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted request gave no response word");

   // a drain cycle always emits a word
   a_drain_emits: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("range drain cycle without response word");

   // a word that is not last means the range is still draining
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final word with no drain in progress");

   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= POS_W'(LIST_DEPTH))
      else $error("fill count beyond list depth");

endmodule

`default_nettype wire

@@ sim/ordered_pair_list_tb.sv @@
// Self-checking testbench for the ordered pair list: directed cases, random traffic, checker.

module ordered_pair_list_tb;
   import ordl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = 16;
   // Cycles with no word moving on either channel before the run is called hung
   localparam int WATCHDOG_LIMIT = 2000;
   // Quiet cycles after the last reply, to catch stray response words
   localparam int DRAIN_TAIL = 8;

   // Opcodes the block does not define: they must change nothing
   localparam logic [OPCODE_W-1:0] OP_SPARE_LOW  = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HIGH = 3'd7;

   // One expected response word
   typedef struct {
      status_type             status;
      logic [DATA_PORT_W-1:0] first;
      logic [DATA_PORT_W-1:0] second;
      logic [COUNT_W-1:0]     count;
      logic                   last;
   } list_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OPCODE_W-1:0]    req_opcode       = '0;
   logic [POS_PORT_W-1:0]  req_position     = '0;
   logic [END_PORT_W-1:0]  req_end_position = '0;
   logic [DATA_PORT_W-1:0] req_first_value  = '0;
   logic [DATA_PORT_W-1:0] req_second_value = '0;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [DATA_PORT_W-1:0] rsp_pair_first;
   logic [DATA_PORT_W-1:0] rsp_pair_second;
   logic [COUNT_W-1:0]     rsp_entry_count;
   logic                   rsp_last;

   // Shadow copy of the list, updated when a request word is taken
   logic [DATA_PORT_W-1:0] held_first[LIST_DEPTH];
   logic [DATA_PORT_W-1:0] held_second[LIST_DEPTH];
   int unsigned            held_count = 0;

   list_reply_type pending_replies[$];
   int        fail_count = 0;
   int        idle_cycles = 0;
   // Chance, in percent, that the sender sits out a given cycle
   int        send_idle_pct = 0;

   ordered_pair_list dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_position     (req_position),
      .req_end_position (req_end_position),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_pair_first   (rsp_pair_first),
      .rsp_pair_second  (rsp_pair_second),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // List predictor
   // ---------------------------------------------------------------------

   // Queue one expected word; the count is always the count after the whole operation
   function automatic void queue_reply(input status_type st,
                                       input logic [DATA_PORT_W-1:0] f,
                                       input logic [DATA_PORT_W-1:0] s,
                                       input logic lst);
      list_reply_type r;
      r.status = st;
      r.first  = f;
      r.second = s;
      r.count  = held_count[COUNT_W-1:0];
      r.last   = lst;
      pending_replies.insert(pending_replies.size(), r);
   endfunction

   // Drop one entry and close the gap behind it
   function automatic void drop_entry(input int unsigned p);
      int unsigned i;
      for (i = p; i + 1 < held_count; i++) begin
         held_first[i]  = held_first[i + 1];
         held_second[i] = held_second[i + 1];
      end
      held_count--;
   endfunction

   // Apply one request word to the shadow list and queue the words it should produce
   function automatic void apply_list_word(input logic [OPCODE_W-1:0]    op,
                                           input logic [POS_PORT_W-1:0]  pos,
                                           input logic [END_PORT_W-1:0]  endp,
                                           input logic [DATA_PORT_W-1:0] a,
                                           input logic [DATA_PORT_W-1:0] b);
      logic [DATA_PORT_W-1:0] out_first[LIST_DEPTH];
      logic [DATA_PORT_W-1:0] out_second[LIST_DEPTH];
      int unsigned p;
      int unsigned e;
      int unsigned n;
      int unsigned i;
      p = pos;
      e = endp;
      case (op)
         OP_APPEND: begin
            if (held_count >= LIST_DEPTH) begin
               queue_reply(STAT_FULL, '0, '0, 1'b1);
            end else begin
               held_first[held_count]  = a;
               held_second[held_count] = b;
               held_count++;
               queue_reply(STAT_OK, '0, '0, 1'b1);
            end
         end
         OP_INSERT: begin
            // Full takes precedence over a bad position
            if (held_count >= LIST_DEPTH) begin
               queue_reply(STAT_FULL, '0, '0, 1'b1);
            end else if (p > held_count) begin
               queue_reply(STAT_POS, '0, '0, 1'b1);
            end else begin
               for (i = held_count; i > p; i--) begin
                  held_first[i]  = held_first[i - 1];
                  held_second[i] = held_second[i - 1];
               end
               held_first[p]  = a;
               held_second[p] = b;
               held_count++;
               queue_reply(STAT_OK, '0, '0, 1'b1);
            end
         end
         OP_REMOVE: begin
            if (p >= held_count) begin
               queue_reply(STAT_POS, '0, '0, 1'b1);
            end else begin
               out_first[0]  = held_first[p];
               out_second[0] = held_second[p];
               drop_entry(p);
               queue_reply(STAT_OK, out_first[0], out_second[0], 1'b1);
            end
         end
         OP_RANGE: begin
            // End is checked before ordering
            if (e >= held_count) begin
               queue_reply(STAT_END, '0, '0, 1'b1);
            end else if (p > e) begin
               queue_reply(STAT_ORDER, '0, '0, 1'b1);
            end else begin
               n = e - p + 1;
               for (i = 0; i < n; i++) begin
                  out_first[i]  = held_first[p];
                  out_second[i] = held_second[p];
                  drop_entry(p);
               end
               for (i = 0; i < n; i++)
                  queue_reply(STAT_OK, out_first[i], out_second[i], i + 1 == n);
            end
         end
         OP_READ: begin
            if (p >= held_count)
               queue_reply(STAT_POS, '0, '0, 1'b1);
            else
               queue_reply(STAT_OK, held_first[p], held_second[p], 1'b1);
         end
         default: queue_reply(STAT_OK, '0, '0, 1'b1);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Response checker: compare every response word with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      list_reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $error("response word with nothing expected: status %0d first %h second %h",
                   rsp_status, rsp_pair_first, rsp_pair_second);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_pair_first !== want.first) begin
               $error("rsp_pair_first: expected %h, got %h", want.first, rsp_pair_first);
               fail_count++;
            end
            if (rsp_pair_second !== want.second) begin
               $error("rsp_pair_second: expected %h, got %h", want.second, rsp_pair_second);
               fail_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("rsp_entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0b, got %0b", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: reset the count whenever a word moves on either channel
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly random data, with the all-zero and all-one patterns mixed in
   function automatic logic [DATA_PORT_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Present one request word and wait until it is taken. Always entered and left
   // just after a rising edge. Leave start high on return, so back-to-back words
   // never see start dropped and raised within one time step.
   task automatic send_word(input logic [OPCODE_W-1:0]    op,
                            input logic [POS_PORT_W-1:0]  pos,
                            input logic [END_PORT_W-1:0]  endp,
                            input logic [DATA_PORT_W-1:0] a,
                            input logic [DATA_PORT_W-1:0] b);
      // Sit out a random number of cycles first, start low
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      start            <= 1'b1;
      req_opcode       <= op;
      req_position     <= pos;
      req_end_position <= endp;
      req_first_value  <= a;
      req_second_value <= b;
      // Hold the word until an edge sees busy low
      do @(posedge clock); while (busy !== 1'b0);
      apply_list_word(op, pos, endp, a, b);
   endtask

   // Drop start and wait for every outstanding response word
   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every access to an empty list must be refused
   task automatic test_empty_list();
      send_word(OP_READ, 5'd0, 4'd0, rand_value(), rand_value());
      send_word(OP_REMOVE, 5'd16, 4'd0, rand_value(), rand_value());
      send_word(OP_RANGE, 5'd0, 4'd0, rand_value(), rand_value());
      // Insert past the end
      send_word(OP_INSERT, 5'd1, 4'd0, rand_value(), rand_value());
   endtask

   // Undefined opcodes leave the list alone and answer with one plain word
   task automatic test_spare_opcodes();
      int op;
      for (op = OP_SPARE_LOW; op <= OP_SPARE_HIGH; op++)
         send_word(OPCODE_W'(op), '1, '1, '1, '1);
   endtask

   // Build the list to capacity through every add path, then overflow it
   task automatic test_fill_and_overflow();
      // Insert at the end of an empty list, then append extremes
      send_word(OP_INSERT, 5'd0, 4'd0, '1, '0);
      send_word(OP_APPEND, 5'd0, 4'd0, '0, '1);
      // Insert at the front and in the middle
      send_word(OP_INSERT, 5'd0, 4'd0, rand_value(), rand_value());
      send_word(OP_INSERT, 5'd1, 4'd0, rand_value(), rand_value());
      while (held_count < LIST_DEPTH)
         send_word(OP_APPEND, '1, '1, rand_value(), rand_value());
      send_word(OP_APPEND, 5'd0, 4'd0, rand_value(), rand_value());
      // Full must win over the bad position
      send_word(OP_INSERT, 5'd31, 4'd0, rand_value(), rand_value());
   endtask

   // Range checks at the top of the list, then empty it in one sweep
   task automatic test_range_limits();
      // End is in range, start is past it
      send_word(OP_RANGE, 5'd16, 4'd15, rand_value(), rand_value());
      send_word(OP_READ, 5'd15, 4'd0, rand_value(), rand_value());
      send_word(OP_REMOVE, 5'd15, 4'd0, rand_value(), rand_value());
      // Both limits wrong: the end check must be reported
      send_word(OP_RANGE, 5'd16, 4'd15, rand_value(), rand_value());
      send_word(OP_INSERT, 5'd15, 4'd0, '1, '1);
      // Longest burst: all sixteen pairs back to back
      send_word(OP_RANGE, 5'd0, 4'd15, rand_value(), rand_value());
   endtask

   // Random operations, biased so the list swings between empty and full
   task automatic test_random_traffic(input int words, input int idle_pct);
      int          w;
      int unsigned pick;
      int unsigned fill;
      int unsigned span;
      int unsigned add_share;
      int unsigned first_pos;
      int unsigned last_pos;
      logic [OPCODE_W-1:0] op;
      bit          grow;
      send_idle_pct = idle_pct;
      grow = 1'b1;
      for (w = 0; w < words; w++) begin
         fill = held_count;
         // Flip between filling and draining now and then
         if (fill < 3)
            grow = 1'b1;
         else if (fill == LIST_DEPTH && $urandom_range(0, 3) == 0)
            grow = 1'b0;
         else if ($urandom_range(0, 29) == 0)
            grow = !grow;
         add_share = grow ? 60 : 25;
         first_pos = 0;
         last_pos  = 0;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            // Noise: any opcode, any position
            op        = OPCODE_W'($urandom_range(0, 7));
            first_pos = $urandom_range(0, 31);
            last_pos  = $urandom_range(0, 15);
         end else if (pick < 5 + add_share / 2) begin
            op = OP_APPEND;
         end else if (pick < 5 + add_share) begin
            op        = OP_INSERT;
            first_pos = $urandom_range(0, fill + 1);
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  op = OP_REMOVE;
                  if (fill != 0)
                     first_pos = $urandom_range(0, fill - 1);
               end
               1: begin
                  op = OP_RANGE;
                  if (fill != 0) begin
                     first_pos = $urandom_range(0, fill - 1);
                     span      = fill - 1 - first_pos;
                     if ($urandom_range(0, 9) == 0)
                        last_pos = $urandom_range(first_pos, fill - 1);
                     else
                        last_pos = first_pos + $urandom_range(0, span < 2 ? span : 2);
                  end
                  // Occasionally break the range
                  if ($urandom_range(0, 15) == 0)
                     last_pos = $urandom_range(0, 15);
               end
               default: begin
                  op        = OP_READ;
                  first_pos = $urandom_range(0, fill);
               end
            endcase
         end
         send_word(op, POS_PORT_W'(first_pos), END_PORT_W'(last_pos),
                   rand_value(), rand_value());
      end
      // Let the list go quiet before the next phase
      hold_until_drained();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed cases run with the sender at full rate
      send_idle_pct = 0;
      test_empty_list();
      test_spare_opcodes();
      test_fill_and_overflow();
      test_range_limits();
      hold_until_drained();

      // Random phases: no idling, heavy sender idling, light sender idling
      test_random_traffic(160, 0);
      test_random_traffic(160, 85);
      test_random_traffic(160, 14);

      // Watch for stray response words after the last expected one
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
